@@ src/assert_macros.svh @@
// Assertion macros shared by the rate limiter RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/psrl_pkg.sv @@
// Shared types, constants and the reciprocal table of the rate limiter.
// Depends on nothing; used by every module of the block.
package psrl_pkg;

  // Table size and derived widths.
  localparam int MAX_USERS = 64;
  localparam int IDX_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CNT_W     = $clog2(MAX_USERS + 1);

  // Field widths.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int PER_W   = 24;
  localparam int DIV_W   = 9;
  localparam int PMUL_W  = 4;
  localparam int NUM_W   = COUNT_W + PMUL_W;

  // Decay rule constants.
  localparam logic [DIV_W-1:0]   PERIOD_SECONDS = DIV_W'(360);
  localparam logic [COUNT_W-1:0] SMALL_COUNT    = COUNT_W'(10);
  localparam logic [PER_W-1:0]   CLEAR_PERIODS  = PER_W'(10);

  // floor(2^32 / 360): reciprocal of the period length.
  localparam logic [DATA_W-1:0] RECIP_PERIOD = DATA_W'(32'd11930464);

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT     = 2'd0;
  localparam logic [1:0] ST_OVER_LIMIT = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  // One write into the user table.
  typedef struct packed {
    logic               user_we;
    logic               count_we;
    logic [IDX_W-1:0]   addr;
    logic [DATA_W-1:0]  user;
    logic [COUNT_W-1:0] count;
  } tbl_wr_t;

  // floor(2^32 / p) for the small period counts that need a true divide.
  function automatic logic [DATA_W-1:0] recip_of(input logic [PMUL_W-1:0] p);
    logic [DATA_W-1:0] r;
    case (p)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/psrl_rdiv.sv @@
// Shared divide unit: quotient and remainder by reciprocal multiply and one correction.
// Depends on psrl_pkg; start is registered into v1 and then into done, in step with the data.
module psrl_rdiv import psrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DIV_W-1:0]  den,
  input  logic [DATA_W-1:0] recip,
  output logic              done,
  output logic [DATA_W-1:0] quot,
  output logic [DIV_W-1:0]  rem
);

  logic [2*DATA_W-1:0]     prod;
  logic [DATA_W-1:0]       num_q;
  logic [DIV_W-1:0]        den_q;
  logic                    v1;
  logic [DATA_W-1:0]       q0;
  logic [DATA_W+DIV_W-1:0] back_full;
  logic [DATA_W-1:0]       r0;
  logic [DATA_W-1:0]       r1;
  logic                    fix;

  // First stage: estimate the quotient with the reciprocal.
  always_ff @(posedge clk) begin
    prod  <= num * recip;
    num_q <= num;
    den_q <= den;
  end

  // The estimate is low by at most one, so one compare and subtract settles it.
  always_comb begin
    q0        = prod[2*DATA_W-1:DATA_W];
    back_full = q0 * den_q;
    r0        = num_q - back_full[DATA_W-1:0];
    r1        = r0 - DATA_W'(den_q);
    fix       = (r0 >= DATA_W'(den_q));
  end

  // Second stage: corrected quotient and remainder.
  always_ff @(posedge clk) begin
    quot <= fix ? q0 + 1'b1 : q0;
    rem  <= fix ? r1[DIV_W-1:0] : r0[DIV_W-1:0];
  end

  // Valid pipe beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

endmodule

@@ src/psrl_table.sv @@
// User table: user ids and submission counts, one write and one read per cycle.
// Depends on psrl_pkg; read data is registered, contents undefined until written.
module psrl_table import psrl_pkg::*; (
  input  logic               clk,
  input  tbl_wr_t            wr,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [DATA_W-1:0]  rd_user,
  output logic [COUNT_W-1:0] rd_count
);

  logic [DATA_W-1:0]  user_mem  [MAX_USERS];
  logic [COUNT_W-1:0] count_mem [MAX_USERS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.user_we) begin
      user_mem[wr.addr] <= wr.user;
    end
    if (wr.count_we) begin
      count_mem[wr.addr] <= wr.count;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_user  <= user_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
  end

endmodule

@@ src/per_user_submit_rate_limiter_core.sv @@
// Per-user submit rate limiter: each request item gives exactly one result item.
// Depends on psrl_pkg, psrl_rdiv, psrl_table and assert_macros.svh.

// The block takes one request item at a time and is not ready again until its
// result item has been taken. An item with a zero limit goes from S_START
// straight to the result. Otherwise the cost is set by the user table and the
// shared divide unit: S_START and S_PDIV work out the elapsed periods, then, when
// at least one period passed, S_DRD and S_DLD visit each stored user whose count
// decays by subtraction or clears, and S_DMUL and S_DDIV follow for a user whose
// count is scaled through the divide unit; then S_SRD and S_SCMP visit each stored
// user for the lookup, and S_SCMP or S_INS does the update or insert before S_OUT
// gives the result. The table holds up to 64 users and needs no clearing after reset.
`include "assert_macros.svh"

module per_user_submit_rate_limiter_core import psrl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [DATA_W-1:0]  user_id,
  input  logic [DATA_W-1:0]  now_seconds,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] user_count
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_START = 11'b000_0000_0010,
    S_PDIV  = 11'b000_0000_0100,
    S_DRD   = 11'b000_0000_1000,
    S_DLD   = 11'b000_0001_0000,
    S_DMUL  = 11'b000_0010_0000,
    S_DDIV  = 11'b000_0100_0000,
    S_SRD   = 11'b000_1000_0000,
    S_SCMP  = 11'b001_0000_0000,
    S_INS   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] limit;
  logic               started;
  logic [DATA_W-1:0]  ref_time;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   idx;
  logic [PER_W-1:0]   periods;
  logic [NUM_W-1:0]   num_reg;
  logic [DATA_W-1:0]  user_q;
  logic [DATA_W-1:0]  now_q;

  logic [CNT_W-1:0]   idx_inc;
  logic               idx_last;
  logic               table_full;
  logic [PMUL_W-1:0]  p_small;
  logic [PMUL_W-1:0]  p_minus;

  tbl_wr_t            wr;
  logic [DATA_W-1:0]  rd_user;
  logic [COUNT_W-1:0] rd_count;

  logic               div_start;
  logic [DATA_W-1:0]  div_num;
  logic [DIV_W-1:0]   div_den;
  logic [DATA_W-1:0]  div_recip;
  logic               div_done;
  logic [DATA_W-1:0]  div_quot;
  logic [DIV_W-1:0]   div_rem;

  logic               small_cnt;
  logic               direct_decay;
  logic [COUNT_W-1:0] decay_val;
  logic               hit;
  logic               under_limit;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);

  // Loop bookkeeping.
  assign idx_inc    = idx + 1'b1;
  assign idx_last   = (idx_inc == used);
  assign table_full = (used >= CNT_W'(MAX_USERS));
  assign p_small    = periods[PMUL_W-1:0];
  assign p_minus    = p_small - 1'b1;

  // Decay of one stored count: subtraction for small counts, clear for long gaps or a single period.
  always_comb begin
    small_cnt    = (rd_count <= SMALL_COUNT);
    direct_decay = small_cnt || (periods >= CLEAR_PERIODS) || (periods == PER_W'(1));
    decay_val    = '0;
    if (small_cnt && (PER_W'(rd_count) > periods)) begin
      decay_val = rd_count - periods[COUNT_W-1:0];
    end
  end

  // Lookup compare against the entry just read.
  assign hit         = (rd_user == user_q);
  assign under_limit = (rd_count < limit);

  // Operand selection for the shared divide unit.
  assign div_start = ((state == S_START) && (limit != '0) && started && (now_q >= ref_time))
                     || (state == S_DMUL);
  always_comb begin
    if (state == S_DMUL) begin
      div_num   = DATA_W'(num_reg);
      div_den   = DIV_W'(p_small);
      div_recip = recip_of(p_small);
    end else begin
      div_num   = now_q - ref_time;
      div_den   = PERIOD_SECONDS;
      div_recip = RECIP_PERIOD;
    end
  end

  psrl_rdiv u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .recip (div_recip),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Table write selection.
  always_comb begin
    wr       = '0;
    wr.addr  = idx[IDX_W-1:0];
    wr.user  = user_q;
    unique case (state)
      S_DLD: begin
        wr.count_we = direct_decay;
        wr.count    = direct_decay ? decay_val : '0;
      end
      S_DDIV: begin
        wr.count_we = div_done;
        wr.count    = div_quot[COUNT_W-1:0];
      end
      S_SCMP: begin
        wr.count_we = hit && under_limit;
        wr.count    = rd_count + 1'b1;
      end
      S_INS: begin
        wr.user_we  = !table_full;
        wr.count_we = !table_full;
        wr.addr     = used[IDX_W-1:0];
        wr.count    = COUNT_W'(1);
      end
      default: begin
        wr.count_we = 1'b0;
      end
    endcase
  end

  psrl_table u_table (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (idx[IDX_W-1:0]),
    .rd_user  (rd_user),
    .rd_count (rd_count)
  );

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      user_q <= user_id;
      now_q  <= now_seconds;
    end
  end

  // Sequencer: period count, decay sweep, lookup, insert, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      started  <= 1'b0;
      ref_time <= '0;
      used     <= '0;
      idx      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          idx <= '0;
          if (limit == '0) begin
            status     <= ST_ACCEPT;
            user_count <= '0;
            state      <= S_OUT;
          end else if (!started) begin
            started  <= 1'b1;
            ref_time <= now_q;
            state    <= (used == '0) ? S_INS : S_SRD;
          end else if (now_q < ref_time) begin
            state <= (used == '0) ? S_INS : S_SRD;
          end else begin
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            if (div_quot == '0) begin
              state <= (used == '0) ? S_INS : S_SRD;
            end else begin
              ref_time <= now_q - DATA_W'(div_rem);
              periods  <= div_quot[PER_W-1:0];
              state    <= (used == '0) ? S_INS : S_DRD;
            end
          end
        end
        S_DRD: begin
          state <= S_DLD;
        end
        S_DLD: begin
          if (direct_decay) begin
            idx   <= idx_last ? '0 : idx_inc;
            state <= idx_last ? S_SRD : S_DRD;
          end else begin
            num_reg <= NUM_W'(rd_count) * NUM_W'(p_minus);
            state   <= S_DMUL;
          end
        end
        S_DMUL: begin
          state <= S_DDIV;
        end
        S_DDIV: begin
          if (div_done) begin
            idx   <= idx_last ? '0 : idx_inc;
            state <= idx_last ? S_SRD : S_DRD;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (hit) begin
            status     <= under_limit ? ST_ACCEPT : ST_OVER_LIMIT;
            user_count <= under_limit ? rd_count + 1'b1 : rd_count;
            state      <= S_OUT;
          end else if (idx_last) begin
            state <= S_INS;
          end else begin
            idx   <= idx_inc;
            state <= S_SRD;
          end
        end
        S_INS: begin
          if (table_full) begin
            status     <= ST_TABLE_FULL;
            user_count <= '0;
          end else begin
            status     <= ST_ACCEPT;
            user_count <= COUNT_W'(1);
            used       <= used + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The request side and the result side are never open at once.
  `ASSERT_ALWAYS(a_one_side_open, clk, rst, !(req_ready && rsp_valid))
  // The fill count never passes the table size.
  `ASSERT_ALWAYS(a_used_bound, clk, rst, used <= CNT_W'(MAX_USERS))
  // An insert into a table with room grows the fill count by one.
  `ASSERT_NEXT(a_insert_grows, clk, rst, (state == S_INS) && !table_full, used == $past(used) + 1'b1)
  // Divide results only arrive while the sequencer waits for them.
  `ASSERT_IMPLY(a_div_expected, clk, rst, div_done, (state == S_PDIV) || (state == S_DDIV))
  // A table-full result only comes from a full table and carries a zero count.
  `ASSERT_IMPLY(a_full_result, clk, rst, rsp_valid && (status == ST_TABLE_FULL), (user_count == '0) && table_full)

endmodule
